[hw/rtl/mfap_pkg.sv]
// Shared constants, opcodes and controller/datapath interface types for the max-flow engine.
`default_nettype none
package mfap_pkg;
   localparam int NODES  = 64;
   localparam int NODE_W = 6;
   localparam int ADDR_W = 2 * NODE_W;
   localparam int CAP_W  = 24;
   localparam int FLOW_W = 25;
   localparam int RES_W  = 26;
   localparam int SUM_W  = 30;
   localparam int AMT_W  = 16;
   localparam int CNT_W  = NODE_W + 1;

   localparam logic [CAP_W-1:0] CAP_MAX  = 24'hFFFFFF;
   localparam logic [SUM_W-1:0] SUM_MAX  = 30'h3FFFFFFF;
   localparam logic [SUM_W-1:0] PATH_INF = 30'd1000000000;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_BOTH  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_RUN   = 2'd3;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_RUN_INIT,
      DP_SWEEP_ALL,
      DP_SWEEP_FLOW,
      DP_LD_RDF,
      DP_LD_WRF,
      DP_LD_RDR,
      DP_LD_WRR,
      DP_BFS_INIT,
      DP_POP,
      DP_SCAN,
      DP_MIN_INIT,
      DP_MIN_RD,
      DP_MIN_UPD,
      DP_AUG_INIT,
      DP_AUG_RDF,
      DP_AUG_WRF,
      DP_AUG_RDR,
      DP_AUG_WRR,
      DP_SUM,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       src_eq_snk;
      logic       sweep_last;
      logic       nxt_last;
      logic       queue_more;
      logic       snk_seen;
      logic       p_at_src;
      logic       rsp_free;
   } dp_sts_type;
endpackage
`default_nettype wire

[hw/rtl/mfap_ctrl.sv]
// Sequencer for loads, matrix sweeps, breadth-first search and path augmentation.
`default_nettype none
module mfap_ctrl
   import mfap_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  dp_sts_type  sts,
   output dp_cmd_type  cmd
);
   typedef enum logic [21:0] {
      S_SWEEP_ALL  = 22'h000001,
      S_IDLE       = 22'h000002,
      S_DISPATCH   = 22'h000004,
      S_LD_RDF     = 22'h000008,
      S_LD_WRF     = 22'h000010,
      S_LD_RDR     = 22'h000020,
      S_LD_WRR     = 22'h000040,
      S_SWEEP_FLOW = 22'h000080,
      S_BFS_INIT   = 22'h000100,
      S_CHECK      = 22'h000200,
      S_SCAN       = 22'h000400,
      S_DRAIN      = 22'h000800,
      S_MIN_INIT   = 22'h001000,
      S_MIN_RD     = 22'h002000,
      S_MIN_UPD    = 22'h004000,
      S_AUG_INIT   = 22'h008000,
      S_AUG_RDF    = 22'h010000,
      S_AUG_WRF    = 22'h020000,
      S_AUG_RDR    = 22'h040000,
      S_AUG_WRR    = 22'h080000,
      S_SUM        = 22'h100000,
      S_EMIT       = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP_ALL;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      case (state_ff)
         S_SWEEP_ALL: begin
            cmd.op = DP_SWEEP_ALL;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = DP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.func)
               FUNC_ADD, FUNC_BOTH: state_in = S_LD_RDF;
               FUNC_CLEAR:          state_in = S_SWEEP_ALL;
               FUNC_RUN: begin
                  cmd.op   = DP_RUN_INIT;
                  state_in = sts.src_eq_snk ? S_EMIT : S_SWEEP_FLOW;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_LD_RDF: begin
            cmd.op   = DP_LD_RDF;
            state_in = S_LD_WRF;
         end
         S_LD_WRF: begin
            cmd.op   = DP_LD_WRF;
            state_in = (sts.func == FUNC_BOTH) ? S_LD_RDR : S_IDLE;
         end
         S_LD_RDR: begin
            cmd.op   = DP_LD_RDR;
            state_in = S_LD_WRR;
         end
         S_LD_WRR: begin
            cmd.op   = DP_LD_WRR;
            state_in = S_IDLE;
         end
         S_SWEEP_FLOW: begin
            cmd.op = DP_SWEEP_FLOW;
            if (sts.sweep_last) state_in = S_BFS_INIT;
         end
         S_BFS_INIT: begin
            cmd.op   = DP_BFS_INIT;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.queue_more && !sts.snk_seen) begin
               cmd.op   = DP_POP;
               state_in = S_SCAN;
            end else if (sts.snk_seen) begin
               state_in = S_MIN_INIT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            cmd.op = DP_SCAN;
            if (sts.nxt_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_MIN_INIT: begin
            cmd.op   = DP_MIN_INIT;
            state_in = S_MIN_RD;
         end
         S_MIN_RD: begin
            if (sts.p_at_src) begin
               state_in = S_AUG_INIT;
            end else begin
               cmd.op   = DP_MIN_RD;
               state_in = S_MIN_UPD;
            end
         end
         S_MIN_UPD: begin
            cmd.op   = DP_MIN_UPD;
            state_in = S_MIN_RD;
         end
         S_AUG_INIT: begin
            cmd.op   = DP_AUG_INIT;
            state_in = S_AUG_RDF;
         end
         S_AUG_RDF: begin
            if (sts.p_at_src) begin
               state_in = S_SUM;
            end else begin
               cmd.op   = DP_AUG_RDF;
               state_in = S_AUG_WRF;
            end
         end
         S_AUG_WRF: begin
            cmd.op   = DP_AUG_WRF;
            state_in = S_AUG_RDR;
         end
         S_AUG_RDR: begin
            cmd.op   = DP_AUG_RDR;
            state_in = S_AUG_WRR;
         end
         S_AUG_WRR: begin
            cmd.op   = DP_AUG_WRR;
            state_in = S_AUG_RDF;
         end
         S_SUM: begin
            cmd.op   = DP_SUM;
            state_in = S_BFS_INIT;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.op   = DP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/mfap_dp.sv]
// Datapath: capacity and flow memories, search trace, queue, bottleneck and total registers.
`default_nettype none
module mfap_dp
   import mfap_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  wire  [1:0]        req_func,
   input  wire  [NODE_W-1:0] req_from,
   input  wire  [NODE_W-1:0] req_to,
   input  wire  [AMT_W-1:0]  req_amount,
   input  wire               csr_wen,
   input  wire  [NODE_W-1:0] csr_wdata,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [SUM_W-1:0]  rsp_total
);
   logic [CAP_W-1:0]  cap_mem  [NODES*NODES];
   logic [FLOW_W-1:0] flow_mem [NODES*NODES];
   logic [CAP_W-1:0]  cap_rd_ff;
   logic [FLOW_W-1:0] flow_rd_ff;

   logic [1:0]        func_ff;
   logic [NODE_W-1:0] src_ff, snk_ff, last_ff;
   logic [AMT_W-1:0]  amt_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic [NODES-1:0]  seen_ff;
   logic [NODE_W-1:0] parent_ff [NODES];
   logic [NODE_W-1:0] queue_ff  [NODES];
   logic [CNT_W-1:0]  head_ff, tail_ff;
   logic [NODE_W-1:0] here_ff, nxt_ff, pend_node_ff, p_ff, q_ff;
   logic [NODE_W-1:0] p_in;
   logic              pend_ff;
   logic [SUM_W-1:0]  push_ff, sum_ff;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  rsp_data_ff;

   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              cap_we, flow_we;
   logic [CAP_W-1:0]  cap_wd;
   logic [FLOW_W-1:0] flow_wd;
   logic [CAP_W:0]    cap_sum;
   logic [CAP_W-1:0]  cap_sat;
   logic [RES_W-1:0]  res;
   logic              res_pos;
   logic [NODE_W-1:0] q_node;
   logic [SUM_W:0]    total_sum;
   logic              take;

   assign q_node  = q_ff;
   assign cap_sum = {1'b0, cap_rd_ff} + {{(CAP_W+1-AMT_W){1'b0}}, amt_ff};
   assign cap_sat = cap_sum[CAP_W] ? CAP_MAX : cap_sum[CAP_W-1:0];
   assign res     = {2'b00, cap_rd_ff} - {flow_rd_ff[FLOW_W-1], flow_rd_ff};
   assign res_pos = !res[RES_W-1] && (res != '0);
   assign total_sum = {1'b0, sum_ff} + {1'b0, push_ff};
   assign take    = pend_ff && !seen_ff[pend_node_ff] && res_pos;

   always_comb begin
      rd_addr = '0;
      wr_addr = '0;
      cap_we  = 1'b0;
      flow_we = 1'b0;
      cap_wd  = '0;
      flow_wd = '0;
      case (cmd.op)
         DP_SWEEP_ALL: begin
            wr_addr = sweep_ff;
            cap_we  = 1'b1;
            flow_we = 1'b1;
         end
         DP_SWEEP_FLOW: begin
            wr_addr = sweep_ff;
            flow_we = 1'b1;
         end
         DP_LD_RDF: rd_addr = {src_ff, snk_ff};
         DP_LD_RDR: rd_addr = {snk_ff, src_ff};
         DP_LD_WRF: begin
            wr_addr = {src_ff, snk_ff};
            cap_we  = 1'b1;
            cap_wd  = cap_sat;
         end
         DP_LD_WRR: begin
            wr_addr = {snk_ff, src_ff};
            cap_we  = 1'b1;
            cap_wd  = cap_sat;
         end
         DP_SCAN:    rd_addr = {here_ff, nxt_ff};
         DP_MIN_RD:  rd_addr = {q_node, p_ff};
         DP_AUG_RDF: rd_addr = {q_node, p_ff};
         DP_AUG_RDR: rd_addr = {p_ff, q_node};
         DP_AUG_WRF: begin
            wr_addr = {q_node, p_ff};
            flow_we = 1'b1;
            flow_wd = flow_rd_ff + push_ff[FLOW_W-1:0];
         end
         DP_AUG_WRR: begin
            wr_addr = {p_ff, q_node};
            flow_we = 1'b1;
            flow_wd = flow_rd_ff - push_ff[FLOW_W-1:0];
         end
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cap_we)  cap_mem[wr_addr]  <= cap_wd;
      if (flow_we) flow_mem[wr_addr] <= flow_wd;
      cap_rd_ff  <= cap_mem[rd_addr];
      flow_rd_ff <= flow_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 6'd63;
      end else if (csr_wen) begin
         last_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LATCH) begin
         func_ff <= req_func;
         src_ff  <= req_from;
         snk_ff  <= req_to;
         amt_ff  <= req_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.op == DP_SWEEP_ALL || cmd.op == DP_SWEEP_FLOW) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (cmd.op == DP_SCAN);
         if (cmd.op == DP_BFS_INIT) begin
            seen_ff <= {{(NODES-1){1'b0}}, 1'b1} << src_ff;
            head_ff <= '0;
            tail_ff <= CNT_W'(1);
         end else begin
            if (cmd.op == DP_POP) head_ff <= head_ff + 1'b1;
            if (take) begin
               seen_ff[pend_node_ff] <= 1'b1;
               if (!tail_ff[CNT_W-1]) tail_ff <= tail_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      case (cmd.op)
         DP_MIN_INIT, DP_AUG_INIT: p_in = snk_ff;
         DP_MIN_UPD, DP_AUG_WRR:   p_in = q_ff;
         default:                  p_in = p_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      pend_node_ff <= nxt_ff;
      p_ff         <= p_in;
      q_ff         <= parent_ff[p_in];
      if (cmd.op == DP_BFS_INIT) begin
         parent_ff[src_ff] <= src_ff;
         queue_ff[0]       <= src_ff;
      end else if (take) begin
         parent_ff[pend_node_ff] <= here_ff;
         if (!tail_ff[CNT_W-1]) queue_ff[tail_ff[NODE_W-1:0]] <= pend_node_ff;
      end
      case (cmd.op)
         DP_POP: begin
            here_ff <= queue_ff[head_ff[NODE_W-1:0]];
            nxt_ff  <= '0;
         end
         DP_SCAN: nxt_ff <= nxt_ff + 1'b1;
         DP_MIN_INIT: push_ff <= PATH_INF;
         DP_MIN_UPD: begin
            if ({{(SUM_W-RES_W){1'b0}}, res} < push_ff) begin
               push_ff <= {{(SUM_W-RES_W){1'b0}}, res};
            end
         end
         default: push_ff <= push_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_RUN_INIT) begin
         sum_ff <= '0;
      end else if (cmd.op == DP_SUM) begin
         sum_ff <= total_sum[SUM_W] ? SUM_MAX : total_sum[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == DP_EMIT) rsp_data_ff <= sum_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_total  = rsp_data_ff;

   assign sts.func       = func_ff;
   assign sts.src_eq_snk = (src_ff == snk_ff);
   assign sts.sweep_last = (sweep_ff == {ADDR_W{1'b1}});
   assign sts.nxt_last   = (nxt_ff == last_ff);
   assign sts.queue_more = (head_ff < tail_ff);
   assign sts.snk_seen   = seen_ff[snk_ff];
   assign sts.p_at_src   = (p_ff == src_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;
endmodule
`default_nettype wire

[hw/rtl/max_flow_augmenting_path.sv]
// Max-flow engine: a load beat holds the input while it updates one capacity (both
// directions for FUNC_BOTH), a clear beat while it zeroes both matrix memories. A run beat
// sweeps the flow memory, then each search scans nodes 0 to highest_node per dequeued node
// and each path is walked edge by edge; throughput is one beat at a time, set by the sequential controller walk.
// Reset (synchronous) clears both matrix memories; req_tready stays low.
`default_nettype none
module max_flow_augmenting_path
   import mfap_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // from_node[5:0], to_node[11:6], amount[27:12], zero pad
   input  wire  [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // total_flow[29:0], zero pad
   input  wire         csr_wen,
   input  wire  [5:0]  csr_wdata
);
   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic [SUM_W-1:0] total;

   mfap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mfap_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_tuser),
      .req_from   (req_tdata[5:0]),
      .req_to     (req_tdata[11:6]),
      .req_amount (req_tdata[27:12]),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_total  (total)
   );

   assign rsp_tdata = {2'b00, total};
endmodule
`default_nettype wire
